// File: rtl/mlrs_pkg.sv
// Shared types, sizes and codes of the mutual list relation scan block.
// Used by the controller, the datapath and the top level; depends on nothing.
package mlrs_pkg;

    localparam int SLOTS       = 1024;
    localparam int MAX_FRIENDS = 16;
    localparam int MAX_REJECTS = 16;
    localparam int MAX_MATCHES = 32;

    localparam int ID_W    = 31;
    localparam int SLOT_PW = 10;
    localparam int OP_W    = 2;
    localparam int VIEW_W  = 4;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int FCNT_W = $clog2(MAX_FRIENDS + 1);
    localparam int RCNT_W = $clog2(MAX_REJECTS + 1);
    localparam int FIDX_W = (MAX_FRIENDS > 1) ? $clog2(MAX_FRIENDS) : 1;
    localparam int RIDX_W = (MAX_REJECTS > 1) ? $clog2(MAX_REJECTS) : 1;
    localparam int MC_W   = $clog2(MAX_MATCHES + 1);

    localparam logic [OP_W-1:0] OP_START  = 2'd0;
    localparam logic [OP_W-1:0] OP_FRIEND = 2'd1;
    localparam logic [OP_W-1:0] OP_REJECT = 2'd2;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd3;

    localparam logic RD_ITEM = 1'b0;
    localparam logic RD_PEER = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [FCNT_W-1:0] fcnt;
        logic [RCNT_W-1:0] rcnt;
        logic              fclosed;
        logic              rclosed;
    } slot_word_t;

    typedef logic [MAX_FRIENDS-1:0][ID_W-1:0] frow_t;
    typedef logic [MAX_REJECTS-1:0][ID_W-1:0] rrow_t;

    typedef struct packed {
        logic clr_we;
        logic cap;
        logic rd_en;
        logic rd_sel;
        logic wr_slot;
        logic q_init;
        logic load_me;
        logic p_inc;
        logic push;
        logic final_emit;
    } cmd_t;

    typedef struct packed {
        logic            clr_done;
        logic            in_range;
        logic [OP_W-1:0] op;
        logic            p_last;
        logic            hit;
        logic            m_last;
        logic            pend_v;
        logic            out_vld;
    } status_t;

endpackage

// File: rtl/mlrs_ctrl.sv
// Controller state machine of the relation scan block.
// Depends on mlrs_pkg for the command and status structs and operation codes.
module mlrs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              out_stall,
    input  mlrs_pkg::status_t st,
    output mlrs_pkg::cmd_t    cmd
);
    import mlrs_pkg::*;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_WSTART = 4'd2;
    localparam logic [3:0] S_WRD    = 4'd3;
    localparam logic [3:0] S_WWR    = 4'd4;
    localparam logic [3:0] S_QRD    = 4'd5;
    localparam logic [3:0] S_QLD    = 4'd6;
    localparam logic [3:0] S_SRD    = 4'd7;
    localparam logic [3:0] S_SEV    = 4'd8;
    localparam logic [3:0] S_FINAL  = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_free;

    assign out_free = !st.out_vld || !out_stall;
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_we = 1'b1;
                if (st.clr_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.cap    = 1'b1;
                    state_next = S_QRD;
                end
            end
            S_QRD:
            begin
                // The captured item is decoded here, in the cycle after its transfer.
                if (st.op == OP_START)
                    state_next = S_WSTART;
                else if (st.op != OP_QUERY)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_ITEM;
                    state_next = S_WWR;
                end
                else if (!st.in_range)
                    state_next = S_FINAL;
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_ITEM;
                    cmd.q_init = 1'b1;
                    state_next = S_QLD;
                end
            end
            S_WSTART:
            begin
                cmd.wr_slot = 1'b1;
                state_next  = S_IDLE;
            end
            S_WRD:
            begin
                state_next = S_WWR;
            end
            S_WWR:
            begin
                cmd.wr_slot = 1'b1;
                state_next  = S_IDLE;
            end
            S_QLD:
            begin
                cmd.load_me = 1'b1;
                state_next  = S_SRD;
            end
            S_SRD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_PEER;
                state_next = S_SEV;
            end
            S_SEV:
            begin
                if (!(st.hit && st.pend_v && !out_free))
                begin
                    cmd.push = st.hit;
                    if (st.p_last || (st.hit && st.m_last))
                        state_next = S_FINAL;
                    else
                    begin
                        cmd.p_inc  = 1'b1;
                        state_next = S_SRD;
                    end
                end
            end
            S_FINAL:
            begin
                if (out_free)
                begin
                    cmd.final_emit = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule

// File: rtl/mlrs_dp.sv
// Datapath of the relation scan block: slot table, list memories, scan registers.
// Depends on mlrs_pkg; driven by mlrs_ctrl through cmd_t and reports in status_t.
module mlrs_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [mlrs_pkg::OP_W-1:0]     operation,
    input  logic [mlrs_pkg::SLOT_PW-1:0]  slot,
    input  logic [mlrs_pkg::ID_W-1:0]     user_id,
    input  logic                          out_stall,
    input  mlrs_pkg::cmd_t                cmd,
    output mlrs_pkg::status_t             st,
    output logic                          out_valid,
    output logic [mlrs_pkg::SLOT_PW-1:0]  peer_slot,
    output logic [mlrs_pkg::ID_W-1:0]     peer_user_id,
    output logic [mlrs_pkg::VIEW_W-1:0]   my_view,
    output logic [mlrs_pkg::VIEW_W-1:0]   peer_view,
    output logic                          found,
    output logic                          last
);
    import mlrs_pkg::*;

    slot_word_t slot_mem [SLOTS];
    frow_t      fl_mem [SLOTS];
    rrow_t      rl_mem [SLOTS];

    logic [OP_W-1:0]    c_op_reg;
    logic [SLOT_PW-1:0] c_slot_reg;
    logic [ID_W-1:0]    c_id_reg;
    logic               c_in_range;
    logic [SLOT_W-1:0]  c_addr;

    slot_word_t rd_word_reg;
    frow_t      rd_fl_reg;
    rrow_t      rd_rl_reg;

    logic [ID_W-1:0]   my_id_reg;
    logic [FCNT_W-1:0] my_fcnt_reg;
    logic [RCNT_W-1:0] my_rcnt_reg;
    frow_t             my_fl_reg;
    rrow_t             my_rl_reg;

    logic [SLOT_W-1:0] clr_cnt_reg;
    logic [SLOT_W-1:0] p_reg;
    logic [MC_W-1:0]   mcount_reg;

    logic               pend_v_reg;
    logic [SLOT_PW-1:0] pend_slot_reg;
    logic [ID_W-1:0]    pend_id_reg;
    logic [VIEW_W-1:0]  pend_view_reg;

    logic               out_v_reg;
    logic [SLOT_PW-1:0] o_slot_reg;
    logic [ID_W-1:0]    o_id_reg;
    logic [VIEW_W-1:0]  o_my_reg;
    logic [VIEW_W-1:0]  o_peer_reg;
    logic               o_found_reg;
    logic               o_last_reg;

    logic              we;
    logic [SLOT_W-1:0] wa;
    slot_word_t        wd;
    logic              fl_we;
    logic              rl_we;
    logic [SLOT_W-1:0] ra;

    logic [VIEW_W-1:0] view;
    logic              m_fr_peer;
    logic              m_fr_me;
    logic              m_rj_peer;
    logic              m_rj_me;

    assign c_in_range = (int'(c_slot_reg) < SLOTS);
    assign c_addr     = SLOT_W'(c_slot_reg);
    assign ra         = (cmd.rd_sel == RD_PEER) ? p_reg : c_addr;

    // Write port: clearing pass after reset, or the update of one item.
    always_comb
    begin
        we    = 1'b0;
        fl_we = 1'b0;
        rl_we = 1'b0;
        wa    = c_addr;
        wd    = rd_word_reg;
        if (cmd.clr_we)
        begin
            we = 1'b1;
            wa = clr_cnt_reg;
            wd = '0;
        end
        else if (cmd.wr_slot && c_in_range)
        begin
            case (c_op_reg)
                OP_START:
                begin
                    we    = 1'b1;
                    wd    = '0;
                    wd.id = c_id_reg;
                end
                OP_FRIEND:
                begin
                    if (!rd_word_reg.fclosed)
                    begin
                        if (c_id_reg == '0)
                        begin
                            we         = 1'b1;
                            wd.fclosed = 1'b1;
                        end
                        else if (rd_word_reg.fcnt < FCNT_W'(MAX_FRIENDS))
                        begin
                            we      = 1'b1;
                            fl_we   = 1'b1;
                            wd.fcnt = FCNT_W'(rd_word_reg.fcnt + 1'b1);
                        end
                    end
                end
                OP_REJECT:
                begin
                    if (!rd_word_reg.rclosed)
                    begin
                        if (c_id_reg == '0)
                        begin
                            we         = 1'b1;
                            wd.rclosed = 1'b1;
                        end
                        else if (rd_word_reg.rcnt < RCNT_W'(MAX_REJECTS))
                        begin
                            we      = 1'b1;
                            rl_we   = 1'b1;
                            wd.rcnt = RCNT_W'(rd_word_reg.rcnt + 1'b1);
                        end
                    end
                end
                default:
                begin
                    we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            slot_mem[wa] <= wd;
        if (fl_we)
            fl_mem[wa][rd_word_reg.fcnt[FIDX_W-1:0]] <= c_id_reg;
        if (rl_we)
            rl_mem[wa][rd_word_reg.rcnt[RIDX_W-1:0]] <= c_id_reg;
        if (cmd.rd_en)
        begin
            rd_word_reg <= slot_mem[ra];
            rd_fl_reg   <= fl_mem[ra];
            rd_rl_reg   <= rl_mem[ra];
        end
    end

    // Captured item and the querier's own lists.
    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            c_op_reg   <= operation;
            c_slot_reg <= slot;
            c_id_reg   <= user_id;
        end
        if (cmd.load_me)
        begin
            my_id_reg   <= rd_word_reg.id;
            my_fcnt_reg <= rd_word_reg.fcnt;
            my_rcnt_reg <= rd_word_reg.rcnt;
            my_fl_reg   <= rd_fl_reg;
            my_rl_reg   <= rd_rl_reg;
        end
    end

    // Four membership tests against the peer row that was just read.
    always_comb
    begin
        m_fr_peer = 1'b0;
        m_fr_me   = 1'b0;
        m_rj_peer = 1'b0;
        m_rj_me   = 1'b0;
        for (int k = 0; k < MAX_FRIENDS; k++)
        begin
            if ((FCNT_W'(k) < my_fcnt_reg) && (my_fl_reg[k] == rd_word_reg.id))
                m_fr_peer = 1'b1;
            if ((FCNT_W'(k) < rd_word_reg.fcnt) && (rd_fl_reg[k] == my_id_reg))
                m_fr_me = 1'b1;
        end
        for (int k = 0; k < MAX_REJECTS; k++)
        begin
            if ((RCNT_W'(k) < my_rcnt_reg) && (my_rl_reg[k] == rd_word_reg.id))
                m_rj_peer = 1'b1;
            if ((RCNT_W'(k) < rd_word_reg.rcnt) && (rd_rl_reg[k] == my_id_reg))
                m_rj_me = 1'b1;
        end
    end

    assign view = {m_rj_me, m_rj_peer, m_fr_me, m_fr_peer};

    always_comb
    begin
        st          = '0;
        st.clr_done = (clr_cnt_reg == SLOT_W'(SLOTS - 1));
        st.in_range = c_in_range;
        st.op       = c_op_reg;
        st.p_last   = (p_reg == SLOT_W'(SLOTS - 1));
        st.hit      = (view != '0) && (p_reg != c_addr) && (rd_word_reg.id != '0);
        st.m_last   = (mcount_reg == MC_W'(MAX_MATCHES - 1));
        st.pend_v   = pend_v_reg;
        st.out_vld  = out_v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            p_reg       <= '0;
            mcount_reg  <= '0;
            pend_v_reg  <= 1'b0;
            out_v_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.clr_we)
                clr_cnt_reg <= SLOT_W'(clr_cnt_reg + 1'b1);
            if (cmd.q_init)
            begin
                p_reg      <= '0;
                mcount_reg <= '0;
                pend_v_reg <= 1'b0;
            end
            else if (cmd.p_inc)
                p_reg <= SLOT_W'(p_reg + 1'b1);
            if (cmd.push)
            begin
                mcount_reg <= MC_W'(mcount_reg + 1'b1);
                pend_v_reg <= 1'b1;
            end
            if (cmd.final_emit)
                pend_v_reg <= 1'b0;
            if ((cmd.push && pend_v_reg) || cmd.final_emit)
                out_v_reg <= 1'b1;
            else if (out_v_reg && !out_stall)
                out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            pend_slot_reg <= SLOT_PW'(p_reg);
            pend_id_reg   <= rd_word_reg.id;
            pend_view_reg <= view;
        end
        if (cmd.push && pend_v_reg)
        begin
            o_slot_reg  <= pend_slot_reg;
            o_id_reg    <= pend_id_reg;
            o_my_reg    <= pend_view_reg;
            o_peer_reg  <= {pend_view_reg[2], pend_view_reg[3],
                            pend_view_reg[0], pend_view_reg[1]};
            o_found_reg <= 1'b1;
            o_last_reg  <= 1'b0;
        end
        else if (cmd.final_emit)
        begin
            o_last_reg <= 1'b1;
            if (pend_v_reg)
            begin
                o_slot_reg  <= pend_slot_reg;
                o_id_reg    <= pend_id_reg;
                o_my_reg    <= pend_view_reg;
                o_peer_reg  <= {pend_view_reg[2], pend_view_reg[3],
                                pend_view_reg[0], pend_view_reg[1]};
                o_found_reg <= 1'b1;
            end
            else
            begin
                o_slot_reg  <= '0;
                o_id_reg    <= '0;
                o_my_reg    <= '0;
                o_peer_reg  <= '0;
                o_found_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_v_reg;
    assign peer_slot    = o_slot_reg;
    assign peer_user_id = o_id_reg;
    assign my_view      = o_my_reg;
    assign peer_view    = o_peer_reg;
    assign found        = o_found_reg;
    assign last         = o_last_reg;

endmodule

// File: rtl/mutual_list_relation_scan_top.sv
// Top level of the mutual list relation scan block.
// Instantiates mlrs_ctrl and mlrs_dp; depends on mlrs_pkg.
//
// After reset the block clears its slot table, one slot per cycle, holding
// in_stall high all that time. Each input transfer then starts a slot, appends
// a friend or reject entry, or queries a slot. A start goes through the
// transfer, the decode and then the write; an append also reads the table
// during the decode. A query reads the querier's own row, then walks the slots
// in order through the single read port of the table, reading then evaluating
// each slot; the walk ends after the last slot or after MAX_MATCHES (32) found
// results, and the result side can stall it.
// Results of a query come out one per transfer; the final one has last set,
// and a query without any relation gives a single result with found low.
// Input is taken only between items, so in_stall is high while one is worked.
module mutual_list_relation_scan_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [mlrs_pkg::OP_W-1:0]     operation,
    input  logic [mlrs_pkg::SLOT_PW-1:0]  slot,
    input  logic [mlrs_pkg::ID_W-1:0]     user_id,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mlrs_pkg::SLOT_PW-1:0]  peer_slot,
    output logic [mlrs_pkg::ID_W-1:0]     peer_user_id,
    output logic [mlrs_pkg::VIEW_W-1:0]   my_view,
    output logic [mlrs_pkg::VIEW_W-1:0]   peer_view,
    output logic                          found,
    output logic                          last
);
    import mlrs_pkg::*;

    cmd_t    cmd;
    status_t st;

    // The controller only sequences; all storage lives in the datapath.
    mlrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .st        (st),
        .cmd       (cmd)
    );

    // The datapath holds the table, the querier's lists and the output register.
    mlrs_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .operation    (operation),
        .slot         (slot),
        .user_id      (user_id),
        .out_stall    (out_stall),
        .cmd          (cmd),
        .st           (st),
        .out_valid    (out_valid),
        .peer_slot    (peer_slot),
        .peer_user_id (peer_user_id),
        .my_view      (my_view),
        .peer_view    (peer_view),
        .found        (found),
        .last         (last)
    );

endmodule

// File: rtl/mlrs_checker.sv
// Port-level checks of the relation scan block, bound to the top level.
// Depends on mlrs_pkg for field widths.
module mlrs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [mlrs_pkg::ID_W-1:0]     peer_user_id,
    input logic [mlrs_pkg::VIEW_W-1:0]   my_view,
    input logic [mlrs_pkg::VIEW_W-1:0]   peer_view,
    input logic                          found,
    input logic                          last
);
    import mlrs_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> last && (my_view == '0) && (peer_view == '0))
        else $error("empty result not final or not zero");

    a_mirror: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> (peer_view == {my_view[2], my_view[3], my_view[0], my_view[1]})
        && (my_view != '0))
        else $error("peer view is not the mirror of my view");

    a_peer_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> (peer_user_id != '0))
        else $error("relation reported for an empty slot");

endmodule

bind mutual_list_relation_scan_top mlrs_checker u_mlrs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .peer_user_id (peer_user_id),
    .my_view      (my_view),
    .peer_view    (peer_view),
    .found        (found),
    .last         (last)
);
